// ===== hw/rtl/scss_pkg.sv =====
// Package for the SQL comment and whitespace stripper.
// Holds character codes, state encodings, the output word type and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package scss_pkg;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BQUOTE = 8'h60;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam int QUEUE_DEPTH = 3;

   typedef enum logic [1:0] {
      QK_NONE   = 2'd0,
      QK_SINGLE = 2'd1,
      QK_DOUBLE = 2'd2,
      QK_BACK   = 2'd3
   } quote_kind_type;

   typedef enum logic [1:0] {
      CM_NONE  = 2'd0,
      CM_LINE  = 2'd1,
      CM_BLOCK = 2'd2
   } comment_mode_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
   } scss_word_type;

   function automatic logic [7:0] quote_char_of(input quote_kind_type kind);
      logic [7:0] ch;
      unique case (kind)
         QK_SINGLE: ch = CH_SQUOTE;
         QK_DOUBLE: ch = CH_DQUOTE;
         default:   ch = CH_BQUOTE;
      endcase
      return ch;
   endfunction

   function automatic logic is_ws(input logic [7:0] ch);
      return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   endfunction

endpackage

// ===== hw/rtl/scss_req_if.sv =====
// Input channel interface: one SQL text byte and its end-of-text flag per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface scss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       text_end;

   modport source (output valid, output in_char, output text_end, input ready);
   modport sink   (input valid, input in_char, input text_end, output ready);
endinterface

// ===== hw/rtl/scss_rsp_if.sv =====
// Result channel interface: one stripped byte and its last-of-run flag per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface scss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;

   modport source (output valid, output out_char, output run_last, input ready);
   modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== hw/rtl/sql_comment_space_stripper.sv =====
// Top level of the SQL comment and whitespace stripper.
// Depends on scss_pkg, scss_req_if and scss_rsp_if.
//
//   channel  | direction | word fields
//   ---------+-----------+----------------------------
//   req_ch   | in        | in_char[7:0], text_end
//   rsp_ch   | out       | out_char[7:0], run_last
//
// One input byte is taken per cycle while the result queue has room for two
// words after this cycle's pop; the queue drains through a single-word port.
// An accepted byte passes through the input register, then the three-word
// result queue.
// Synchronous active-high reset clears the parse state and empties both stages.
// Output stalls back up into the input only when the queue cannot take two words.
`timescale 1ns / 1ps

module sql_comment_space_stripper
   import scss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   scss_req_if.sink  req_ch,
   scss_rsp_if.source rsp_ch
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int IdxW = $clog2(QUEUE_DEPTH);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;

   // parse state
   quote_kind_type   quote_ff, quote_in;
   comment_mode_type mode_ff, mode_in;
   logic             esc_ff, esc_in;
   logic             slash_ff, slash_in;
   logic             star_ff, star_in;

   // result queue
   scss_word_type q_ff [QUEUE_DEPTH];
   scss_word_type q_in [QUEUE_DEPTH];
   logic [CntW-1:0] count_ff, count_in;

   logic            pop;
   logic            commit;
   logic [CntW-1:0] after_pop;
   logic            emit_pre, emit_char, emit_flush, block_open;
   logic [1:0]      n_words;
   scss_word_type   w0, w1;

   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign after_pop = count_ff - CntW'(pop);
   assign commit    = s1_valid_ff && (after_pop <= CntW'(QUEUE_DEPTH - 2));
   assign req_ch.ready = !s1_valid_ff || commit;
   assign s1_valid_in  = req_ch.valid ? 1'b1 : (s1_valid_ff && !commit);

   assign rsp_ch.valid    = (count_ff != '0);
   assign rsp_ch.out_char = q_ff[0].out_char;
   assign rsp_ch.run_last = q_ff[0].run_last;

   always_comb begin
      quote_in   = quote_ff;
      mode_in    = mode_ff;
      esc_in     = esc_ff;
      slash_in   = slash_ff;
      star_in    = star_ff;
      emit_pre   = 1'b0;
      emit_char  = 1'b0;
      block_open = 1'b0;
      if (quote_ff != QK_NONE) begin
         if (esc_ff) begin
            esc_in = 1'b0;
         end else if (s1_char_ff == CH_BSLASH) begin
            esc_in = 1'b1;
         end else if (s1_char_ff == quote_char_of(quote_ff)) begin
            quote_in = QK_NONE;
         end
         emit_char = 1'b1;
      end else if (mode_ff == CM_LINE) begin
         if (s1_char_ff == CH_NL) begin
            mode_in = CM_NONE;
         end
      end else if (mode_ff != CM_NONE) begin
         if (star_ff && (s1_char_ff == CH_SLASH)) begin
            mode_in = CM_NONE;
            star_in = 1'b0;
         end else begin
            star_in = (s1_char_ff == CH_STAR);
         end
      end else begin
         if (slash_ff) begin
            slash_in = 1'b0;
            if (s1_char_ff == CH_STAR) begin
               mode_in    = CM_BLOCK;
               star_in    = 1'b0;
               block_open = 1'b1;
            end else begin
               emit_pre = 1'b1;
            end
         end
         if (!block_open) begin
            priority if (s1_char_ff == CH_HASH) begin
               mode_in = CM_LINE;
            end else if (s1_char_ff == CH_SLASH) begin
               slash_in = 1'b1;
            end else begin
               priority if (s1_char_ff == CH_SQUOTE) begin
                  quote_in = QK_SINGLE;
               end else if (s1_char_ff == CH_DQUOTE) begin
                  quote_in = QK_DOUBLE;
               end else if (s1_char_ff == CH_BQUOTE) begin
                  quote_in = QK_BACK;
               end else begin
                  quote_in = QK_NONE;
               end
               emit_char = !is_ws(s1_char_ff);
            end
         end
      end
      emit_flush = s1_last_ff && slash_in;
      if (s1_last_ff) begin
         quote_in = QK_NONE;
         mode_in  = CM_NONE;
         esc_in   = 1'b0;
         slash_in = 1'b0;
         star_in  = 1'b0;
      end
   end

   // at most two of the three emits can fire for one byte
   always_comb begin
      n_words = 2'(emit_pre) + 2'(emit_char) + 2'(emit_flush);
      w0.out_char = (emit_char && !emit_pre) ? s1_char_ff : CH_SLASH;
      w0.run_last = (n_words == 2'd1);
      w1.out_char = (emit_pre && emit_char) ? s1_char_ff : CH_SLASH;
      w1.run_last = 1'b1;
   end

   always_comb begin
      q_in     = q_ff;
      count_in = count_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         count_in = after_pop;
      end
      if (commit) begin
         if (n_words != 2'd0) begin
            q_in[IdxW'(count_in)] = w0;
         end
         if (n_words == 2'd2) begin
            q_in[IdxW'(count_in + CntW'(1))] = w1;
         end
         count_in = count_in + CntW'(n_words);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         quote_ff    <= QK_NONE;
         mode_ff     <= CM_NONE;
         esc_ff      <= 1'b0;
         slash_ff    <= 1'b0;
         star_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         if (commit) begin
            quote_ff <= quote_in;
            mode_ff  <= mode_in;
            esc_ff   <= esc_in;
            slash_ff <= slash_in;
            star_ff  <= star_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (req_ch.valid && req_ch.ready) begin
         s1_char_ff <= req_ch.in_char;
         s1_last_ff <= req_ch.text_end;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("result queue over depth");

   a_slash_outside: assert property (@(posedge clock) disable iff (reset)
      slash_ff |-> (quote_ff == QK_NONE) && (mode_ff == CM_NONE))
      else $error("held slash inside quote or comment");

   a_star_in_block: assert property (@(posedge clock) disable iff (reset)
      star_ff |-> (mode_ff == CM_BLOCK))
      else $error("star armed outside block comment");

   a_escape_in_quote: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (quote_ff != QK_NONE))
      else $error("escape pending outside quote");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      commit && s1_last_ff |=> (quote_ff == QK_NONE) && (mode_ff == CM_NONE)
         && !slash_ff && !esc_ff && !star_ff)
      else $error("state not cleared after final byte");

endmodule

// ===== dv/tb_sql_comment_space_stripper.sv =====
// Testbench for sql_comment_space_stripper: directed byte table, then random SQL-like texts.
// Every accepted word is checked against an in-bench stripping predictor or known-row table.
// Depends on scss_pkg, scss_req_if, scss_rsp_if and the top level RTL.
`timescale 1ns / 1ps

module tb_sql_comment_space_stripper;
   import scss_pkg::*;

   localparam int PROBE_ROWS   = 26;
   localparam int RANDOM_BYTES = 450;
   localparam int CALM_TAIL    = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 200000;

   typedef struct packed {
      logic [7:0] code;
      logic       tail;
      logic       known;
      logic [1:0] count;
      logic [7:0] exp_a;
      logic [7:0] exp_b;
   } text_byte_type;

   logic clock;
   logic reset;

   scss_req_if req_ch ();
   scss_rsp_if rsp_ch ();

   sql_comment_space_stripper uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_byte_type    text_bytes[$];
   scss_word_type    stripped[$];
   scss_word_type    awaited[$];
   int               taken       = 0;
   int               errors      = 0;
   int               cycle_count = 0;
   bit               calm        = 1'b0;

   quote_kind_type   quote_now   = QK_NONE;
   logic             quote_esc   = 1'b0;
   logic             slash_wait  = 1'b0;
   comment_mode_type comment_now = CM_NONE;
   logic             star_armed  = 1'b0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   task automatic note_miss(input string what, input int want, input int got);
      errors++;
      if (errors <= 10) begin
         $display("mismatch %0s at cycle %0d: expected %0h, actual %0h",
                  what, cycle_count, want, got);
      end
   endtask

   function automatic void emit_byte(input logic [7:0] ch);
      scss_word_type w;
      w.out_char = ch;
      w.run_last = 1'b0;
      stripped.push_back(w);
   endfunction

   // Predict the words one input byte produces; they land in stripped.
   task automatic strip_byte(input logic [7:0] ch, input logic fin);
      logic [7:0]    closer;
      logic          opened;
      scss_word_type w;
      opened = 1'b0;
      case (quote_now)
         QK_SINGLE: closer = CH_SQUOTE;
         QK_DOUBLE: closer = CH_DQUOTE;
         default:   closer = CH_BQUOTE;
      endcase
      if (quote_now != QK_NONE) begin
         if (quote_esc) begin
            quote_esc = 1'b0;
         end else if (ch == CH_BSLASH) begin
            quote_esc = 1'b1;
         end else if (ch == closer) begin
            quote_now = QK_NONE;
         end
         emit_byte(ch);
      end else if (comment_now == CM_LINE) begin
         if (ch == CH_NL) comment_now = CM_NONE;
      end else if (comment_now != CM_NONE) begin
         if (star_armed && ch == CH_SLASH) begin
            comment_now = CM_NONE;
            star_armed  = 1'b0;
         end else begin
            star_armed = (ch == CH_STAR);
         end
      end else begin
         if (slash_wait) begin
            slash_wait = 1'b0;
            if (ch == CH_STAR) begin
               comment_now = CM_BLOCK;
               star_armed  = 1'b0;
               opened      = 1'b1;
            end else begin
               emit_byte(CH_SLASH);
            end
         end
         if (!opened) begin
            if (ch == CH_HASH) begin
               comment_now = CM_LINE;
            end else if (ch == CH_SLASH) begin
               slash_wait = 1'b1;
            end else begin
               if (ch == CH_SQUOTE) quote_now = QK_SINGLE;
               else if (ch == CH_DQUOTE) quote_now = QK_DOUBLE;
               else if (ch == CH_BQUOTE) quote_now = QK_BACK;
               if (!(ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) emit_byte(ch);
            end
         end
      end
      if (fin) begin
         if (slash_wait) emit_byte(CH_SLASH);
         quote_now   = QK_NONE;
         quote_esc   = 1'b0;
         slash_wait  = 1'b0;
         comment_now = CM_NONE;
         star_armed  = 1'b0;
      end
      if (stripped.size() > 0) begin
         w = stripped.pop_back();
         w.run_last = 1'b1;
         stripped.push_back(w);
      end
   endtask

   // Directed bytes: code, tail, known, count, first and second expected byte.
   function automatic text_byte_type probe_row(input int i);
      text_byte_type r;
      r = '0;
      case (i)
         0:  r = {8'h00,     1'b0, 1'b1, 2'd1, 8'h00, 8'h00};
         1:  r = {8'hFF,     1'b0, 1'b1, 2'd1, 8'hFF, 8'h00};
         2:  r = {CH_SPACE,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00};
         3:  r = {CH_SLASH,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00};
         4:  r = {8'h61,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         5:  r = {CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         6:  r = {CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         7:  r = {CH_HASH,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         8:  r = {8'h78,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         9:  r = {CH_NL,     1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         10: r = {CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         11: r = {CH_TAB,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         12: r = {CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         13: r = {CH_STAR,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         14: r = {CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         15: r = {CH_STAR,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         16: r = {CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         17: r = {CH_STAR,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         18: r = {CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         19: r = {CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         20: r = {CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         21: r = {CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         22: r = {CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         23: r = {CH_BQUOTE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
         24: r = {CH_SLASH,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00};
         default: r = {CH_SLASH, 1'b1, 1'b1, 2'd1, CH_SLASH, 8'h00};
      endcase
      return r;
   endfunction

   function automatic logic [7:0] letter();
      logic [7:0] b;
      b = 8'($urandom_range(8'h61, 8'h7A));
      return b;
   endfunction

   function automatic logic [7:0] blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CH_SPACE : 8'(CH_TAB + 8'(k));
   endfunction

   function automatic logic [7:0] filler();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: b = CH_STAR;
         1: b = CH_SLASH;
         2: b = 8'($urandom_range(0, 255));
         3: b = blank();
         4: b = CH_SQUOTE;
         5: b = CH_DQUOTE;
         6: b = CH_BQUOTE;
         default: b = letter();
      endcase
      return b;
   endfunction

   // Build one SQL-like text from fragments; a few are left unterminated.
   task automatic add_text();
      logic [7:0]    seg[$];
      logic [7:0]    q;
      int            target;
      int            i;
      text_byte_type row;
      target = $urandom_range(1, 24);
      while (seg.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 6)) seg.push_back(letter());
            2: repeat ($urandom_range(1, 3)) seg.push_back(blank());
            3: begin
               case ($urandom_range(0, 2))
                  0: q = CH_SQUOTE;
                  1: q = CH_DQUOTE;
                  default: q = CH_BQUOTE;
               endcase
               seg.push_back(q);
               repeat ($urandom_range(0, 5)) begin
                  if ($urandom_range(0, 3) == 0) seg.push_back(CH_BSLASH);
                  seg.push_back(filler());
               end
               if ($urandom_range(0, 7) != 0) seg.push_back(q);
            end
            4: begin
               seg.push_back(CH_SLASH);
               seg.push_back(CH_STAR);
               repeat ($urandom_range(0, 5)) seg.push_back(filler());
               if ($urandom_range(0, 7) != 0) begin
                  seg.push_back(CH_STAR);
                  seg.push_back(CH_SLASH);
               end
            end
            5: begin
               seg.push_back(CH_HASH);
               repeat ($urandom_range(0, 5)) seg.push_back(filler());
               if ($urandom_range(0, 7) != 0) seg.push_back(CH_NL);
            end
            6: begin
               seg.push_back(CH_SLASH);
               seg.push_back($urandom_range(0, 1) ? letter() : blank());
            end
            7: repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 2))
                  0: seg.push_back(CH_SLASH);
                  1: seg.push_back(CH_STAR);
                  default: seg.push_back(CH_HASH);
               endcase
            end
            default: repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      for (i = 0; i < seg.size(); i++) begin
         row = '0;
         row.code = seg[i];
         row.tail = (i == seg.size() - 1);
         text_bytes.push_back(row);
      end
   endtask

   // Source side: walk the byte list, idle in bursts until the calm tail.
   initial begin : source_side
      int i;
      int calm_from;
      int src_odds;
      int randoms;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.in_char  = 8'h00;
      req_ch.text_end = 1'b0;
      src_odds        = 0;
      for (i = 0; i < PROBE_ROWS; i++) text_bytes.push_back(probe_row(i));
      randoms = 0;
      while (randoms < RANDOM_BYTES) begin
         i = text_bytes.size();
         add_text();
         randoms += text_bytes.size() - i;
      end
      calm_from = text_bytes.size() - CALM_TAIL;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (i = 0; i < text_bytes.size(); i++) begin
         if (i >= calm_from) calm = 1'b1;
         if (i == 0 || text_bytes[i - 1].tail) src_odds = $urandom_range(0, 3);
         if (!calm && src_odds != 0 && $urandom_range(0, 4 * src_odds) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         req_ch.valid    <= 1'b1;
         req_ch.in_char  <= text_bytes[i].code;
         req_ch.text_end <= text_bytes[i].tail;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         @(negedge clock);
      end
      req_ch.valid <= 1'b0;
      while (taken < text_bytes.size() || awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (awaited.size() != 0) note_miss("missing word", awaited.pop_front(), -1);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Sink side: stall in bursts, with quiet stretches in between.
   initial begin : sink_side
      int hold_left;
      int odds;
      int span;
      hold_left    = 0;
      odds         = 0;
      span         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            span = $urandom_range(20, 80);
            odds = $urandom_range(0, 3);
         end
         span--;
         if (hold_left == 0 && !calm && odds != 0 && $urandom_range(0, 4 * odds) == 0) begin
            hold_left = $urandom_range(1, 11);
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Predict on each accepted byte, check each accepted word.
   always @(posedge clock) begin : watch
      text_byte_type row;
      scss_word_type w;
      scss_word_type want;
      cycle_count++;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready && taken < text_bytes.size()) begin
            row = text_bytes[taken];
            taken++;
            stripped.delete();
            strip_byte(req_ch.in_char, req_ch.text_end);
            if (row.known) begin
               stripped.delete();
               if (row.count >= 2'd1) begin
                  w.out_char = row.exp_a;
                  w.run_last = (row.count == 2'd1);
                  stripped.push_back(w);
               end
               if (row.count == 2'd2) begin
                  w.out_char = row.exp_b;
                  w.run_last = 1'b1;
                  stripped.push_back(w);
               end
            end
            while (stripped.size() > 0) awaited.push_back(stripped.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited.size() == 0) begin
               note_miss("unexpected word", -1, {rsp_ch.out_char, rsp_ch.run_last});
            end else begin
               want = awaited.pop_front();
               if (rsp_ch.out_char !== want.out_char)
                  note_miss("out_char", want.out_char, rsp_ch.out_char);
               if (rsp_ch.run_last !== want.run_last)
                  note_miss("run_last", want.run_last, rsp_ch.run_last);
            end
         end
      end
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
